// ===== rtl/huf_pkg.sv =====
// Shared types and constants for the Huffman tree decoder.
// Used by the controller, the datapath, the top level and the checker.
package huf_pkg;

  // Node store geometry and code limits
  localparam int NodeCount  = 512;
  localparam int NodeW      = $clog2(NodeCount);
  localparam int UsedW      = NodeW + 1;
  localparam int MaxCodeLen = 16;
  localparam int PosW       = $clog2(MaxCodeLen);
  localparam int RemW       = PosW + 1;
  localparam int SymW       = 8;
  localparam int ByteW      = 8;

  // Result status codes
  typedef enum logic [1:0] {
    ST_SYMBOL  = 2'd0,
    ST_ACCEPT  = 2'd1,
    ST_FULL    = 2'd2,
    ST_INVALID = 2'd3
  } status_e;

  // Operation select on the input item
  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_DECODE = 1'b1;

  // One node of the code tree: children (0 = none) and leaf symbol
  typedef struct packed {
    logic [NodeW-1:0] left;
    logic [NodeW-1:0] right;
    logic [SymW-1:0]  sym;
  } node_rec_t;

  // Controller states
  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_LWALK = 4'b0010,
    S_LALOC = 4'b0100,
    S_DSTEP = 4'b1000
  } ctrl_state_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;    // latch a new item
    logic walk;       // load: follow an existing child
    logic load_done;  // load: whole code exists, write symbol
    logic load_full;  // load: pool exhausted
    logic link;       // load: hook first new node onto the stop node
    logic alloc;      // load: write one newly allocated node
    logic dec_leaf;   // decode: emit the symbol of the node just reached
    logic dec_bit;    // decode: walk one data bit
    logic dec_finish; // decode: close the item
  } dp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic rem_zero;
    logic child_zero;
    logic pool_full;
    logic leaf_hit;
  } dp_sts_t;

endpackage

// ===== rtl/huffman_tree_decoder_core.sv =====
// Top level of the Huffman tree decoder: controller plus datapath.
// Depends on huf_pkg, huf_ctrl and huf_datapath.
// Usage:
//   Input channel: an item is taken at a clock edge with start high and
//   busy low. func_i selects a code load (0) or a byte decode (1).
//   A load walks code_bits_i from bit code_len_i-1 down, adds missing
//   nodes and stores symbol_in_i at the final node; it returns exactly one
//   result (accepted, or rejected when the node pool would overflow).
//   A decode walks data_byte_i from bit 0 and returns zero to eight
//   results (decoded symbols and invalid-path marks); the tree cursor
//   carries over from one decode item to the next.
//   Output channel: each result is shown for one cycle with result_valid_o;
//   last_o marks the final result of an item. The receiver cannot stall.
//   A load walks the existing nodes of its code, then adds the missing
//   ones (stopping early when refused); a decode steps through its eight
//   data bits with an extra step for each symbol. Both are paced by the
//   node store: one node read or write per code bit. The final result is
//   shown in the first cycle with busy low; a new item may be accepted in it.
//   Reset: the tree holds only an empty root, the pool count is one node
//   and the cursor sits at the root; no clearing pass is needed.
module huffman_tree_decoder_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic                        func_i,
  input  logic [15:0]                 code_bits_i,
  input  logic [4:0]                  code_len_i,
  input  logic [huf_pkg::SymW-1:0]    symbol_in_i,
  input  logic [huf_pkg::ByteW-1:0]   data_byte_i,
  output logic                        result_valid_o,
  output logic [1:0]                  status_o,
  output logic [huf_pkg::SymW-1:0]    symbol_out_o,
  output logic                        last_o
);
  import huf_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  huf_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .func_i (func_i),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy   (busy)
  );

  huf_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .func_i         (func_i),
    .code_bits_i    (code_bits_i),
    .code_len_i     (code_len_i),
    .symbol_in_i    (symbol_in_i),
    .data_byte_i    (data_byte_i),
    .result_valid_o (result_valid_o),
    .status_o       (status_o),
    .symbol_out_o   (symbol_out_o),
    .last_o         (last_o)
  );

endmodule

// ===== rtl/huf_ctrl.sv =====
// Controller state machine for the Huffman tree decoder.
// Depends on huf_pkg; drives the datapath only through dp_cmd_t.
module huf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  logic              func_i,
  input  huf_pkg::dp_sts_t  sts_i,
  output huf_pkg::dp_cmd_t  cmd_o,
  output logic              busy
);
  import huf_pkg::*;

  ctrl_state_e state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.capture = 1'b1;
          state_d = (func_i == FUNC_DECODE) ? S_DSTEP : S_LWALK;
        end
      end
      S_LWALK: begin
        priority if (sts_i.rem_zero) begin
          cmd_o.load_done = 1'b1;
          state_d = S_IDLE;
        end else if (sts_i.child_zero && sts_i.pool_full) begin
          cmd_o.load_full = 1'b1;
          state_d = S_IDLE;
        end else if (sts_i.child_zero) begin
          cmd_o.link = 1'b1;
          state_d = S_LALOC;
        end else begin
          cmd_o.walk = 1'b1;
        end
      end
      S_LALOC: begin
        cmd_o.alloc = 1'b1;
        if (sts_i.rem_zero) state_d = S_IDLE;
      end
      S_DSTEP: begin
        priority if (sts_i.leaf_hit) begin
          cmd_o.dec_leaf = 1'b1;
        end else if (sts_i.rem_zero) begin
          cmd_o.dec_finish = 1'b1;
          state_d = S_IDLE;
        end else begin
          cmd_o.dec_bit = 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign busy = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/huf_datapath.sv =====
// Datapath of the Huffman tree decoder: node store, root node, walk
// counters, pool count, decode cursor and result staging. Uses huf_pkg.
module huf_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  huf_pkg::dp_cmd_t            cmd_i,
  output huf_pkg::dp_sts_t            sts_o,
  input  logic                        func_i,
  input  logic [15:0]                 code_bits_i,
  input  logic [4:0]                  code_len_i,
  input  logic [huf_pkg::SymW-1:0]    symbol_in_i,
  input  logic [huf_pkg::ByteW-1:0]   data_byte_i,
  output logic                        result_valid_o,
  output logic [1:0]                  status_o,
  output logic [huf_pkg::SymW-1:0]    symbol_out_o,
  output logic                        last_o
);
  import huf_pkg::*;

  // Node store (root lives in flops, entry 0 of the array is never used)
  node_rec_t mem [NodeCount];
  node_rec_t rdata_q;
  logic                 mem_we, mem_re;
  logic [NodeW-1:0]     mem_waddr, mem_raddr;
  node_rec_t            mem_wdata;

  // Item registers
  logic                 func_q;
  logic [15:0]          code_q;
  logic [SymW-1:0]      sym_q;
  logic [ByteW-1:0]     byte_q;
  logic [PosW-1:0]      pos_q, pos_d;
  logic [RemW-1:0]      rem_q, rem_d;

  // Tree and walk state
  logic [NodeW-1:0]     root_l_q, root_r_q;
  logic [NodeW-1:0]     rd_node_q, rd_node_d;
  logic [NodeW-1:0]     cursor_q;
  logic [UsedW-1:0]     used_q;
  logic                 chk_q, chk_d;

  // Result staging: one held result so the final one can carry last
  logic                 pend_valid_q, pend_valid_d;
  status_e              pend_status_q;
  logic [SymW-1:0]      pend_sym_q;
  logic                 new_res;
  status_e              new_status;
  logic [SymW-1:0]      new_sym;
  logic                 out_valid_q, out_valid_d;
  status_e              out_status_q, out_status_d;
  logic [SymW-1:0]      out_sym_q, out_sym_d;
  logic                 out_last_q, out_last_d;

  node_rec_t            cur_rec;
  logic                 cur_bit;
  logic [NodeW-1:0]     child;
  logic [NodeW-1:0]     new_idx, next_idx;
  logic [UsedW:0]       used_sum;
  logic [RemW-1:0]      len_eff;

  // Current node record and the child selected by the current bit
  always_comb begin
    cur_rec = (rd_node_q == '0) ? node_rec_t'{left: root_l_q, right: root_r_q, sym: '0}
                                : rdata_q;
    cur_bit = (func_q == FUNC_DECODE) ? byte_q[0] : code_q[pos_q];
    child   = cur_bit ? cur_rec.right : cur_rec.left;
    used_sum = {1'b0, used_q} + (UsedW+1)'(rem_q);
    new_idx  = used_q[NodeW-1:0];
    next_idx = NodeW'(used_q + UsedW'(1));
  end

  assign sts_o.rem_zero   = (rem_q == '0);
  assign sts_o.child_zero = (child == '0);
  assign sts_o.pool_full  = (used_sum > (UsedW+1)'(NodeCount));
  assign sts_o.leaf_hit   = chk_q && (cur_rec.left == '0) && (cur_rec.right == '0);

  assign len_eff = (code_len_i > 5'(MaxCodeLen)) ? RemW'(MaxCodeLen) : RemW'(code_len_i);

  // Node store port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = rd_node_q;
    mem_wdata = cur_rec;
    mem_re    = 1'b0;
    mem_raddr = child;
    if (cmd_i.capture && (func_i == FUNC_DECODE)) begin
      mem_re    = 1'b1;
      mem_raddr = cursor_q;
    end
    if (cmd_i.walk) mem_re = 1'b1;
    if (cmd_i.dec_bit && (child != '0)) mem_re = 1'b1;
    if (cmd_i.link && (rd_node_q != '0)) begin
      mem_we = 1'b1;
      if (cur_bit) mem_wdata.right = new_idx;
      else         mem_wdata.left  = new_idx;
    end
    if (cmd_i.load_done && (rd_node_q != '0)) begin
      mem_we        = 1'b1;
      mem_wdata.sym = sym_q;
    end
    if (cmd_i.alloc) begin
      mem_we    = 1'b1;
      mem_waddr = new_idx;
      mem_wdata = '0;
      if (rem_q == '0) mem_wdata.sym = sym_q;
      else if (cur_bit) mem_wdata.right = next_idx;
      else mem_wdata.left = next_idx;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_q <= mem[mem_raddr];
  end

  // Walk counters and node tracking
  always_comb begin
    pos_d     = pos_q;
    rem_d     = rem_q;
    rd_node_d = rd_node_q;
    chk_d     = chk_q;
    if (cmd_i.capture) begin
      chk_d = 1'b0;
      if (func_i == FUNC_DECODE) begin
        rem_d     = RemW'(ByteW);
        rd_node_d = cursor_q;
      end else begin
        rem_d     = len_eff;
        pos_d     = PosW'(len_eff - RemW'(1));
        rd_node_d = '0;
      end
    end
    if (cmd_i.walk) begin
      rd_node_d = child;
    end
    if (cmd_i.walk || cmd_i.link || (cmd_i.alloc && (rem_q != '0))) begin
      rem_d = rem_q - RemW'(1);
      pos_d = pos_q - PosW'(1);
    end
    if (cmd_i.dec_leaf) begin
      rd_node_d = '0;
      chk_d     = 1'b0;
    end
    if (cmd_i.dec_bit) begin
      rem_d     = rem_q - RemW'(1);
      rd_node_d = child;
      chk_d     = (child != '0);
    end
  end

  // Result selection and staging
  always_comb begin
    new_res    = 1'b0;
    new_status = ST_SYMBOL;
    new_sym    = '0;
    if (cmd_i.dec_leaf) begin
      new_res = 1'b1;
      new_sym = cur_rec.sym;
    end else if (cmd_i.dec_bit && (child == '0)) begin
      new_res    = 1'b1;
      new_status = ST_INVALID;
    end

    pend_valid_d = pend_valid_q;
    out_valid_d  = 1'b0;
    out_status_d = out_status_q;
    out_sym_d    = out_sym_q;
    out_last_d   = out_last_q;
    if (cmd_i.load_done || cmd_i.load_full || (cmd_i.alloc && (rem_q == '0))) begin
      out_valid_d  = 1'b1;
      out_status_d = cmd_i.load_full ? ST_FULL : ST_ACCEPT;
      out_sym_d    = '0;
      out_last_d   = 1'b1;
    end
    if (new_res) begin
      pend_valid_d = 1'b1;
      out_valid_d  = pend_valid_q;
      out_status_d = pend_status_q;
      out_sym_d    = pend_sym_q;
      out_last_d   = 1'b0;
    end
    if (cmd_i.dec_finish) begin
      pend_valid_d = 1'b0;
      out_valid_d  = pend_valid_q;
      out_status_d = pend_status_q;
      out_sym_d    = pend_sym_q;
      out_last_d   = 1'b1;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_l_q     <= '0;
      root_r_q     <= '0;
      used_q       <= UsedW'(1);
      cursor_q     <= '0;
      rd_node_q    <= '0;
      rem_q        <= '0;
      pos_q        <= '0;
      chk_q        <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      rd_node_q    <= rd_node_d;
      rem_q        <= rem_d;
      pos_q        <= pos_d;
      chk_q        <= chk_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
      if (cmd_i.link && (rd_node_q == '0)) begin
        if (cur_bit) root_r_q <= new_idx;
        else         root_l_q <= new_idx;
      end
      if (cmd_i.alloc) used_q <= used_q + UsedW'(1);
      if (cmd_i.dec_finish) cursor_q <= rd_node_q;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q <= func_i;
      code_q <= code_bits_i;
      sym_q  <= symbol_in_i;
      byte_q <= data_byte_i;
    end else if (cmd_i.dec_bit) begin
      byte_q <= byte_q >> 1;
    end
    if (new_res) begin
      pend_status_q <= new_status;
      pend_sym_q    <= new_sym;
    end
    out_status_q <= out_status_d;
    out_sym_q    <= out_sym_d;
    out_last_q   <= out_last_d;
  end

  assign result_valid_o = out_valid_q;
  assign status_o       = out_status_q;
  assign symbol_out_o   = out_sym_q;
  assign last_o         = out_last_q;

endmodule

// ===== rtl/huf_checker.sv =====
// Port-level checks for the Huffman tree decoder, bound to the top level.
// Depends on huf_pkg and huffman_tree_decoder_core.
module huf_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        start,
  input logic                        busy,
  input logic                        result_valid_o,
  input logic [1:0]                  status_o,
  input logic [huf_pkg::SymW-1:0]    symbol_out_o,
  input logic                        last_o
);
  import huf_pkg::*;

  // An accepted item keeps the block busy in the next cycle
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy not raised after item accept");

  // A load has exactly one result, so it is always the last one
  a_load_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (status_o == ST_ACCEPT || status_o == ST_FULL)) |-> last_o)
    else $error("load result without last");

  // Only decoded symbols carry a symbol value
  a_sym_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (status_o != ST_SYMBOL)) |-> (symbol_out_o == '0))
    else $error("nonzero symbol on a non-symbol result");

  // Nothing follows the final result of an item in the next cycle
  a_gap_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && last_o) |=> !result_valid_o)
    else $error("result right after the last one of an item");

endmodule

bind huffman_tree_decoder_core huf_checker u_huf_checker (.*);
